### rtl/core/mfpc_pkg.sv
// Package for the Morton float point comparator: codes, widths and shared types.
// No dependencies.
`default_nettype none
package mfpc_pkg;
    localparam int LEVEL_W = 9;
    localparam logic signed [LEVEL_W-1:0] NO_LEVEL = -9'sd150;
    localparam int EXP_BIAS = 127;
    localparam int MANT_BITS = 23;

    localparam logic [2:0] OP_LE = 3'd0;
    localparam logic [2:0] OP_GE = 3'd1;
    localparam logic [2:0] OP_LT = 3'd2;
    localparam logic [2:0] OP_GT = 3'd3;
    localparam logic [2:0] OP_EQ = 3'd4;

    // per-lane finding
    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      pq_lt;   // p < q on this axis
        logic                      qp_lt;   // q < p on this axis
    } lane_res_t;
endpackage
`default_nettype wire

### rtl/core/mfpc_lane.sv
// One axis lane: level of highest differing bit and both float less-thans.
// Depends on mfpc_pkg.
`default_nettype none
module mfpc_lane (
    input  wire logic [31:0]       a,
    input  wire logic [31:0]       b,
    output mfpc_pkg::lane_res_t    res
);
    logic [7:0]  ea, eb;
    logic [22:0] x;
    logic [4:0]  lead;
    logic        any;
    logic        nan_a, nan_b, zeros;
    logic [31:0] ka, kb;
    logic signed [9:0] lv;

    assign ea = a[30:23];
    assign eb = b[30:23];
    assign x  = a[22:0] ^ b[22:0];

    // leading one of the mantissa difference
    always_comb begin
        lead = 5'd0;
        any  = 1'b0;
        for (int j = 0; j < 23; j++) begin
            if (x[j]) begin
                lead = 5'(j);
                any  = 1'b1;
            end
        end
    end

    // level; a bit-0 difference at exponent zero lands on the no-level value
    always_comb begin
        if (ea == eb) begin
            if (any) begin
                lv = $signed({2'b00, ea}) - 10'sd127 - 10'sd23 + $signed({5'b0, lead});
            end else begin
                lv = 10'(mfpc_pkg::NO_LEVEL);
            end
        end else begin
            lv = $signed({2'b00, (ea > eb) ? ea : eb}) - 10'sd127;
        end
    end

    // IEEE less-than through sign-magnitude to ordered keys
    assign nan_a = (ea == 8'hFF) && (a[22:0] != 23'd0);
    assign nan_b = (eb == 8'hFF) && (b[22:0] != 23'd0);
    assign zeros = ((a | b) & 32'h7FFF_FFFF) == 32'd0;
    assign ka = a[31] ? ~a : (a | 32'h8000_0000);
    assign kb = b[31] ? ~b : (b | 32'h8000_0000);

    assign res.level = lv[8:0];
    assign res.pq_lt = !nan_a && !nan_b && !zeros && (ka < kb);
    assign res.qp_lt = !nan_a && !nan_b && !zeros && (kb < ka);
endmodule
`default_nettype wire

### rtl/core/mfpc_merge.sv
// Merging stage: picks the deciding axis, forms the relation and cell size.
// Depends on mfpc_pkg.
`default_nettype none
module mfpc_merge #(
    parameter int AXES = 3
) (
    input  wire mfpc_pkg::lane_res_t lanes [AXES],
    input  wire logic [2:0]          operation,
    output logic                     relation_holds,
    output logic signed [8:0]        differ_level,
    output logic [31:0]              cell_size_bits
);
    logic signed [8:0] best;
    logic              pq, qp;
    logic signed [9:0] e;

    // strictly greater wins, so the earlier axis keeps ties
    always_comb begin
        best = mfpc_pkg::NO_LEVEL;
        pq   = 1'b1;
        qp   = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            if (lanes[i].level > best) begin
                best = lanes[i].level;
                pq   = lanes[i].pq_lt;
                qp   = lanes[i].qp_lt;
            end
        end
    end

    always_comb begin
        case (operation)
            mfpc_pkg::OP_LE: relation_holds = pq;
            mfpc_pkg::OP_GE: relation_holds = qp;
            mfpc_pkg::OP_LT: relation_holds = !qp;
            mfpc_pkg::OP_GT: relation_holds = !pq;
            mfpc_pkg::OP_EQ: relation_holds = pq && qp;
            default:         relation_holds = 1'b0;
        endcase
    end

    // 2^(level+1) as float bits
    assign e = 10'(best) + 10'sd1;
    always_comb begin
        if (e >= 10'sd128) begin
            cell_size_bits = 32'h7F80_0000;
        end else if (e >= -10'sd126) begin
            cell_size_bits = {1'b0, 8'(e + 10'sd127), 23'd0};
        end else if (e < -10'sd149) begin
            cell_size_bits = 32'd0;
        end else begin
            cell_size_bits = 32'd1 << 5'(e + 10'sd149);
        end
    end

    assign differ_level = best;
endmodule
`default_nettype wire

### rtl/core/morton_float_point_compare.sv
// Morton float point comparator top level: lanes, merge and output skid.
// Depends on mfpc_pkg, mfpc_lane, mfpc_merge.
// Path from input request to result: one input register, then one output register.
// Throughput: one request per cycle; a spare slot on the output takes one more
// request while a result waits, then input stalls. Synchronous active-low reset
// clears valid flags.
`default_nettype none
module morton_float_point_compare #(
    parameter int AXES = 3
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [2:0]   s_tuser,   // operation
    input  wire logic [191:0] s_tdata,   // p_x, p_y, p_z, q_x, q_y, q_z
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata    // relation_holds, differ_level, cell_size_bits, pad
);
    localparam int NA = (AXES > 3) ? 3 : AXES;

    // input stage
    logic         in_v_reg;
    logic [2:0]   op_reg;
    logic [191:0] pts_reg;
    logic         adv;

    // output skid: main and spare slot
    logic        o_v_reg, sk_v_reg;
    logic [41:0] o_d_reg, sk_d_reg;
    logic [41:0] res;

    mfpc_pkg::lane_res_t lanes [NA];

    genvar g;
    generate
        for (g = 0; g < NA; g++) begin : g_lane
            mfpc_lane u_lane (
                .a  (pts_reg[32*g +: 32]),
                .b  (pts_reg[96 + 32*g +: 32]),
                .res(lanes[g])
            );
        end
    endgenerate

    logic        rel;
    logic signed [8:0] lvl;
    logic [31:0] size_bits;

    mfpc_merge #(.AXES(NA)) u_merge (
        .lanes         (lanes),
        .operation     (op_reg),
        .relation_holds(rel),
        .differ_level  (lvl),
        .cell_size_bits(size_bits)
    );
    assign res = {size_bits, lvl, rel};

    assign s_tready = !sk_v_reg;
    assign adv      = s_tready;

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_reg  <= s_tuser;
            pts_reg <= s_tdata;
        end
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (adv) begin
            in_v_reg <= s_tvalid;
        end
    end

    // output register with skid; spare only fills when main is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_v_reg  <= 1'b0;
            sk_v_reg <= 1'b0;
        end else begin
            if (!o_v_reg || m_tready) begin
                if (sk_v_reg) begin
                    o_v_reg  <= 1'b1;
                    o_d_reg  <= sk_d_reg;
                    sk_v_reg <= 1'b0;
                end else begin
                    o_v_reg <= in_v_reg;
                    o_d_reg <= res;
                end
            end else if (in_v_reg && !sk_v_reg) begin
                sk_v_reg <= 1'b1;
                sk_d_reg <= res;
            end
        end
    end

    // in_v_reg is consumed whenever adv; if spare was full adv is low and it holds
    assign m_tvalid = o_v_reg;
    assign m_tdata  = {6'd0, o_d_reg};
endmodule
`default_nettype wire

### bench/morton_float_point_compare_checker.sv
// Checker for the Morton float point comparator: watches both channels, predicts results.
// Depends on mfpc_pkg for widths, operation codes and the no-level constant.
`default_nettype none
module morton_float_point_compare_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [2:0]   s_tuser,   // operation
    input  wire logic [191:0] s_tdata,   // p_x, p_y, p_z, q_x, q_y, q_z
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [47:0]  m_tdata,   // relation_holds, differ_level, cell_size_bits, pad
    output int                fail_count,
    output int                pending
);
    typedef struct packed {
        logic                                holds;
        logic signed [mfpc_pkg::LEVEL_W-1:0] level;
        logic [31:0]                         size_bits;
    } cmp_result_t;

    cmp_result_t expected_q[$];

    // IEEE less-than on raw bits; NaN never less, zeros equal
    function automatic logic ieee_less(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka, kb;
        if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
            return 1'b0;
        if (((a | b) & 32'h7FFF_FFFF) == 0)
            return 1'b0;
        ka = a[31] ? ~a : (a | 32'h8000_0000);
        kb = b[31] ? ~b : (b | 32'h8000_0000);
        return ka < kb;
    endfunction

    // level of the highest differing bit on one axis
    function automatic int axis_place(input logic [31:0] a, input logic [31:0] b);
        int ea, eb;
        logic [22:0] x;
        ea = a[30:23];
        eb = b[30:23];
        if (ea != eb)
            return (ea > eb ? ea : eb) - mfpc_pkg::EXP_BIAS;
        x = a[22:0] ^ b[22:0];
        for (int j = 22; j >= 0; j--)
            if (x[j])
                return ea - mfpc_pkg::EXP_BIAS - (mfpc_pkg::MANT_BITS - j);
        return int'(mfpc_pkg::NO_LEVEL);
    endfunction

    // first <= second in Z-order, with the deciding level
    function automatic logic zorder_le(input logic [95:0] a, input logic [95:0] b,
                                       output int level);
        int best, lv;
        logic res;
        best = int'(mfpc_pkg::NO_LEVEL);
        res = 1'b1;
        for (int i = 0; i < 3; i++) begin
            lv = axis_place(a[32*i +: 32], b[32*i +: 32]);
            if (lv > best) begin
                best = lv;
                res = ieee_less(a[32*i +: 32], b[32*i +: 32]);
            end
        end
        level = best;
        return res;
    endfunction

    function automatic logic [31:0] pow2_float(input int e);
        if (e >= 128) return 32'h7F80_0000;
        if (e >= -126) return 32'(e + mfpc_pkg::EXP_BIAS) << mfpc_pkg::MANT_BITS;
        if (e < -149) return 32'd0;
        return 32'd1 << (e + 149);
    endfunction

    function automatic cmp_result_t predict_compare(input logic [2:0] op,
                                                    input logic [191:0] d);
        cmp_result_t r;
        int lv, lv2;
        logic pq, qp;
        pq = zorder_le(d[95:0], d[191:96], lv);
        qp = zorder_le(d[191:96], d[95:0], lv2);
        case (op)
            mfpc_pkg::OP_LE: r.holds = pq;
            mfpc_pkg::OP_GE: r.holds = qp;
            mfpc_pkg::OP_LT: r.holds = !qp;
            mfpc_pkg::OP_GT: r.holds = !pq;
            mfpc_pkg::OP_EQ: r.holds = pq && qp;
            default:         r.holds = 1'b0;
        endcase
        r.level = lv[mfpc_pkg::LEVEL_W-1:0];
        r.size_bits = pow2_float(lv + 1);
        return r;
    endfunction

    assign pending = expected_q.size();

    // predict on input request, compare on result request
    always @(posedge aclk) begin
        cmp_result_t e;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_q.insert(expected_q.size(), predict_compare(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (m_tdata[0] !== e.holds || m_tdata[9:1] !== e.level ||
                        m_tdata[41:10] !== e.size_bits) begin
                        if (m_tdata[0] !== e.holds)
                            $error("relation_holds exp %0d got %0d", e.holds, m_tdata[0]);
                        if (m_tdata[9:1] !== e.level)
                            $error("differ_level exp %0d got %0d", e.level,
                                   $signed(m_tdata[9:1]));
                        if (m_tdata[41:10] !== e.size_bits)
                            $error("cell_size_bits exp %h got %h", e.size_bits,
                                   m_tdata[41:10]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

### bench/morton_float_point_compare_tb.sv
// Testbench top for the Morton float point comparator: clock, reset, stimulus, verdict.
// Depends on mfpc_pkg, the block and morton_float_point_compare_checker.
`default_nettype none
module morton_float_point_compare_tb;
    localparam int WATCHDOG_LIMIT = 20000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [2:0]   s_tuser = '0;    // operation
    logic [191:0] s_tdata = '0;    // p_x, p_y, p_z, q_x, q_y, q_z
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;         // relation_holds, differ_level, cell_size_bits, pad
    int           fail_count;
    int           pending;
    int           send_idle = 0;
    int           recv_stall = 0;
    int           quiet_cycles = 0;

    always #2 aclk = ~aclk;

    morton_float_point_compare dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    morton_float_point_compare_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver stalls
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    // watchdog on cycles without any request
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0:       return $urandom();
            1:       return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(3))};
            2:       return {1'($urandom_range(1)), 8'h00, 23'($urandom_range(7))};
            3:       return {1'($urandom_range(1)), 8'($urandom_range(120, 134)),
                             23'($urandom())};
            default: return {1'b0, 8'($urandom_range(125, 129)), 23'($urandom())};
        endcase
    endfunction

    // one request; the next value is set in the same edge it is accepted
    task automatic send_pair(input logic [2:0] op, input logic [191:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // random pair, mostly near neighbours so every axis can decide
    task automatic send_random();
        logic [191:0] d;
        logic [95:0]  p;
        logic [31:0]  c;
        for (int i = 0; i < 3; i++) p[32*i +: 32] = rand_coord();
        d[95:0] = p;
        for (int i = 0; i < 3; i++) begin
            c = p[32*i +: 32];
            case ($urandom_range(3))
                0: c = rand_coord();
                1: c = c ^ (32'd1 << $urandom_range(31));
                2: c = c ^ 32'($urandom_range(255));
                default: ;
            endcase
            d[96 + 32*i +: 32] = c;
        end
        send_pair(3'($urandom_range(7)), d);
    endtask

    initial begin
        logic [31:0] dir_vals[12];
        int phase_idle[4];
        int phase_stall[4];
        dir_vals = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0002,
                     32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F7F_FFFF,
                     32'h3F80_0000, 32'h3F80_0001, 32'hFFFF_FFFF, 32'h0080_0000};
        phase_idle = '{0, 86, 0, 38};
        phase_stall = '{0, 0, 86, 38};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identical points, bit-0 only, NaN, zeros, extremes, every code
        for (int op = 0; op < 8; op++)
            send_pair(3'(op), {6{32'h3F80_0000}});
        send_pair(mfpc_pkg::OP_EQ, {96'd1, 96'd0});
        send_pair(mfpc_pkg::OP_LE, {32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0});
        for (int i = 0; i < 12; i++)
            send_pair(3'(i % 5), {32'd0, 32'd0, dir_vals[(i + 5) % 12],
                                  32'd0, 32'd0, dir_vals[i]});
        send_pair(mfpc_pkg::OP_GT, {96'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF, 96'd0});
        send_pair(mfpc_pkg::OP_LT, {32'h7F80_0000, 32'h0, 32'h0, 32'h0, 32'h7F80_0000, 32'h0});

        // random, over all idling phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = phase_idle[ph];
            recv_stall = phase_stall[ph];
            for (int n = 0; n < 325; n++) send_random();
        end
        s_tvalid <= 1'b0;
        recv_stall = 0;

        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
rtl/core/mfpc_pkg.sv
rtl/core/mfpc_lane.sv
rtl/core/mfpc_merge.sv
rtl/core/morton_float_point_compare.sv
bench/morton_float_point_compare_checker.sv
bench/morton_float_point_compare_tb.sv
